FILE: rtl/core/frf_pkg.sv
// Package with shared types and constants of the fixed frame receiver.
`default_nettype none
package frf_pkg;

  // Frame format.
  localparam logic [7:0] HeaderByte         = 8'hAA;
  localparam int unsigned PayloadBytesDef   = 16;
  localparam int unsigned HeaderFieldBytes  = 4;

  // Offsets of the header fields among the body bytes.
  localparam int unsigned OfsVersion        = 0;
  localparam int unsigned OfsSource         = 1;
  localparam int unsigned OfsDestination    = 2;
  localparam int unsigned OfsSequence       = 3;

  // Configuration port.
  localparam int unsigned CfgIdxW           = 8;
  localparam logic [CfgIdxW-1:0] CfgLocalAddr = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgBcastAddr = 8'd1;
  localparam logic [7:0] LocalAddrRst       = 8'h01;
  localparam logic [7:0] BcastAddrRst       = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_frame;  // header seen, restart the body count
    logic take_byte;    // store the accepted body byte
    logic read_mem;     // fetch the payload byte at the result index
    logic load_drop;    // load the dropped-frame result
    logic advance;      // step the result index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_header;    // input byte is the header byte
    logic body_last;    // next stored body byte completes the frame
    logic addr_match;   // destination is local or broadcast
    logic last_idx;     // result index is on the final payload byte
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/fixed_frame_receiver_address_filter.sv
// Top level of the fixed frame receiver with destination address filter.
// Bytes are taken one per cycle while hunting for the header and while receiving a frame.
// After the last frame byte is taken the destination is checked; for a kept frame each
// result is preceded by a payload memory read, and a dropped frame gives a single result.
// No byte is taken while a frame is checked or its results are offered.
// Reset restores the controller, counters and address registers, not the frame buffer.
`default_nettype none
module fixed_frame_receiver_address_filter #(
  parameter int unsigned PAYLOAD_BYTES = frf_pkg::PayloadBytesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             status_o,
  output logic [7:0]                       payload_byte_o,
  output logic [3:0]                       byte_index_o,
  output logic [7:0]                       protocol_version_o,
  output logic [7:0]                       source_address_o,
  output logic [7:0]                       destination_address_o,
  output logic [7:0]                       sequence_number_o,
  output logic [15:0]                      frame_crc_o,
  output logic                             last_of_frame_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [frf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i
);

  frf_pkg::cmd_t    cmd;
  frf_pkg::status_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Controller.
  frf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  frf_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .rx_byte_i             (rx_byte_i),
    .cfg_we_i              (cfg_valid_i && cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .status_o              (status_o),
    .payload_byte_o        (payload_byte_o),
    .byte_index_o          (byte_index_o),
    .protocol_version_o    (protocol_version_o),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .sequence_number_o     (sequence_number_o),
    .frame_crc_o           (frame_crc_o),
    .last_of_frame_o       (last_of_frame_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/frf_ctrl.sv
// Controller state machine of the fixed frame receiver.
`default_nettype none
module frf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire frf_pkg::status_t sts_i,
  output frf_pkg::cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    S_HUNT = 5'b00001,
    S_BODY = 5'b00010,
    S_EVAL = 5'b00100,
    S_READ = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   drop_q, drop_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    drop_d      = drop_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_HUNT: begin
        in_stall_o = 1'b0;
        if (in_valid_i && sts_i.is_header) begin
          cmd_o.start_frame = 1'b1;
          state_d = S_BODY;
        end
      end
      S_BODY: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_byte = 1'b1;
          if (sts_i.body_last) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (sts_i.addr_match) begin
          drop_d  = 1'b0;
          state_d = S_READ;
        end else begin
          drop_d          = 1'b1;
          cmd_o.load_drop = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_READ: begin
        cmd_o.read_mem = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (drop_q || sts_i.last_idx) begin
            state_d = S_HUNT;
          end else begin
            cmd_o.advance = 1'b1;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_HUNT;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/frf_datapath.sv
// Datapath of the fixed frame receiver: buffers, counters and result registers.
`default_nettype none
module frf_datapath #(
  parameter int unsigned PAYLOAD_BYTES = frf_pkg::PayloadBytesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [frf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i,
  input  wire frf_pkg::cmd_t               cmd_i,
  output frf_pkg::status_t                 sts_o,
  output logic                             status_o,
  output logic [7:0]                       payload_byte_o,
  output logic [3:0]                       byte_index_o,
  output logic [7:0]                       protocol_version_o,
  output logic [7:0]                       source_address_o,
  output logic [7:0]                       destination_address_o,
  output logic [7:0]                       sequence_number_o,
  output logic [15:0]                      frame_crc_o,
  output logic                             last_of_frame_o
);

  localparam int unsigned BodyBytes = PAYLOAD_BYTES + 6;
  localparam int unsigned CntW      = $clog2(BodyBytes);
  localparam int unsigned IdxW      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int unsigned OfsPay    = frf_pkg::HeaderFieldBytes;
  localparam int unsigned OfsCrcHi  = PAYLOAD_BYTES + 4;
  localparam int unsigned OfsCrcLo  = PAYLOAD_BYTES + 5;

  logic [7:0]      local_q, bcast_q;
  logic [7:0]      ver_q, src_q, dst_q, seq_q, crc_hi_q, crc_lo_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_status_q, out_last_q;
  logic [7:0]      rdata_q;
  logic [7:0]      pay_mem [PAYLOAD_BYTES];
  logic [CntW-1:0] pay_ofs;
  logic            is_pay;
  logic [IdxW+3:0] out_idx_ext;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= frf_pkg::LocalAddrRst;
      bcast_q <= frf_pkg::BcastAddrRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == frf_pkg::CfgLocalAddr) begin
        local_q <= cfg_data_i;
      end else if (cfg_index_i == frf_pkg::CfgBcastAddr) begin
        bcast_q <= cfg_data_i;
      end
    end
  end

  // Body byte counter and result index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.start_frame) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        if (cmd_i.take_byte) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        if (cmd_i.advance) begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  assign pay_ofs = cnt_q - CntW'(OfsPay);
  assign is_pay  = (cnt_q >= CntW'(OfsPay)) && (cnt_q < CntW'(OfsCrcHi));

  // Header and CRC field registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      case (cnt_q)
        CntW'(frf_pkg::OfsVersion):     ver_q    <= rx_byte_i;
        CntW'(frf_pkg::OfsSource):      src_q    <= rx_byte_i;
        CntW'(frf_pkg::OfsDestination): dst_q    <= rx_byte_i;
        CntW'(frf_pkg::OfsSequence):    seq_q    <= rx_byte_i;
        CntW'(OfsCrcHi):                crc_hi_q <= rx_byte_i;
        CntW'(OfsCrcLo):                crc_lo_q <= rx_byte_i;
        default: begin
        end
      endcase
    end
  end

  // Payload memory: one write port while receiving, registered read while emitting.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && is_pay) begin
      pay_mem[pay_ofs[IdxW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.read_mem) begin
      rdata_q <= pay_mem[idx_q];
    end else if (cmd_i.load_drop) begin
      rdata_q <= '0;
    end
  end

  // Result flag and index registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_mem) begin
      out_status_q <= 1'b0;
      out_idx_q    <= idx_q;
      out_last_q   <= (idx_q == IdxW'(PAYLOAD_BYTES - 1));
    end else if (cmd_i.load_drop) begin
      out_status_q <= 1'b1;
      out_idx_q    <= '0;
      out_last_q   <= 1'b1;
    end
  end

  // Status back to the controller.
  assign sts_o.is_header  = (rx_byte_i == frf_pkg::HeaderByte);
  assign sts_o.body_last  = (cnt_q == CntW'(BodyBytes - 1));
  assign sts_o.addr_match = (dst_q == local_q) || (dst_q == bcast_q);
  assign sts_o.last_idx   = (idx_q == IdxW'(PAYLOAD_BYTES - 1));

  // Result payload.
  assign out_idx_ext           = {4'b0000, out_idx_q};
  assign status_o              = out_status_q;
  assign payload_byte_o        = rdata_q;
  assign byte_index_o          = out_idx_ext[3:0];
  assign protocol_version_o    = ver_q;
  assign source_address_o      = src_q;
  assign destination_address_o = dst_q;
  assign sequence_number_o     = seq_q;
  assign frame_crc_o           = {crc_hi_q, crc_lo_q};
  assign last_of_frame_o       = out_last_q;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench of the fixed frame receiver with destination address filter.
`timescale 1ns / 1ps
module testbench;

  localparam int PayloadBytes = frf_pkg::PayloadBytesDef;
  localparam int BodyBytes    = PayloadBytes + 6;
  localparam int FrameBytes   = BodyBytes + 1;
  localparam int DrainCycles  = 3 + 2 * PayloadBytes + 16;
  localparam int CycleLimit   = 200000;
  localparam int HoldCycles   = 400;

  localparam logic StatusDelivered = 1'b0;
  localparam logic StatusDropped   = 1'b1;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [frf_pkg::CfgIdxW-1:0] CfgIdxUnused = 8'hFF;

  // Payload patterns for generated frames.
  localparam int PayRandom  = 0;
  localparam int PayCorners = 1;

  // Idle percentages of the sender and the receiver.
  localparam int IdleRare  = 17;
  localparam int IdleOften = 88;
  localparam int IdleNone  = 0;

  typedef struct packed {
    logic        status;
    logic [7:0]  payload;
    logic [3:0]  index;
    logic [7:0]  version;
    logic [7:0]  source;
    logic [7:0]  destination;
    logic [7:0]  sequence_no;
    logic [15:0] crc;
    logic        last;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [7:0] rx_byte_i;
  logic out_valid_o;
  logic out_stall_i;
  logic status_o;
  logic [7:0] payload_byte_o;
  logic [3:0] byte_index_o;
  logic [7:0] protocol_version_o;
  logic [7:0] source_address_o;
  logic [7:0] destination_address_o;
  logic [7:0] sequence_number_o;
  logic [15:0] frame_crc_o;
  logic last_of_frame_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [frf_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  // Receiver state as the predictor sees it.
  logic [4:0] rx_pos;
  logic [7:0] frame_body [BodyBytes];
  logic [7:0] local_addr_q;
  logic [7:0] bcast_addr_q;
  frame_result_t expected_q [$];

  int tx_gap_pct;
  int rx_stall_pct;
  int hold_left;
  int cycle_cnt;
  int mismatches;
  int results_checked;
  int bytes_taken;
  int frames_kept;
  int frames_dropped;

  fixed_frame_receiver_address_filter dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .payload_byte_o        (payload_byte_o),
    .byte_index_o          (byte_index_o),
    .protocol_version_o    (protocol_version_o),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .sequence_number_o     (sequence_number_o),
    .frame_crc_o           (frame_crc_o),
    .last_of_frame_o       (last_of_frame_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_cnt,
               expected_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall: random, or forced high during a hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < rx_stall_pct);
  end

  // Computes the results that one accepted received byte causes.
  function automatic void predict_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [15:0] crc;
    logic [7:0] dst;
    if (rx_pos == 5'd0) begin
      if (b == frf_pkg::HeaderByte) begin
        rx_pos = 5'd1;
        bytes_taken++;
      end
      return;
    end
    bytes_taken++;
    frame_body[rx_pos - 5'd1] = b;
    rx_pos = rx_pos + 5'd1;
    if (rx_pos <= BodyBytes) begin
      return;
    end
    rx_pos = 5'd0;
    dst = frame_body[frf_pkg::OfsDestination];
    crc = {frame_body[BodyBytes - 2], frame_body[BodyBytes - 1]};
    r.version     = frame_body[frf_pkg::OfsVersion];
    r.source      = frame_body[frf_pkg::OfsSource];
    r.destination = dst;
    r.sequence_no = frame_body[frf_pkg::OfsSequence];
    r.crc         = crc;
    if (dst != local_addr_q && dst != bcast_addr_q) begin
      r.status  = StatusDropped;
      r.payload = 8'h00;
      r.index   = 4'd0;
      r.last    = 1'b1;
      expected_q.push_back(r);
      frames_dropped++;
      return;
    end
    for (int k = 0; k < PayloadBytes; k++) begin
      r.status  = StatusDelivered;
      r.payload = frame_body[frf_pkg::HeaderFieldBytes + k];
      r.index   = k[3:0];
      r.last    = (k == PayloadBytes - 1);
      expected_q.push_back(r);
    end
    frames_kept++;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compares every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual payload %0h status %0b",
                 $time, payload_byte_o, status_o);
      end else begin
        want = expected_q.pop_front();
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("payload_byte", 16'(want.payload), 16'(payload_byte_o));
        check_field("byte_index", 16'(want.index), 16'(byte_index_o));
        check_field("protocol_version", 16'(want.version), 16'(protocol_version_o));
        check_field("source_address", 16'(want.source), 16'(source_address_o));
        check_field("destination_address", 16'(want.destination),
                    16'(destination_address_o));
        check_field("sequence_number", 16'(want.sequence_no), 16'(sequence_number_o));
        check_field("frame_crc", want.crc, frame_crc_o);
        check_field("last_of_frame", 16'(want.last), 16'(last_of_frame_o));
        results_checked++;
      end
    end
  end

  // Offers one byte after random idle cycles and waits for the transaction.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_rx_byte(b);
  endtask

  // Sends the first n_bytes of a frame, header byte included.
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] src,
                            input logic [7:0] dst, input logic [7:0] seq,
                            input logic [15:0] crc, input int pattern, input int n_bytes);
    logic [7:0] b;
    for (int j = 0; j < n_bytes; j++) begin
      case (j)
        0: b = frf_pkg::HeaderByte;
        1: b = ver;
        2: b = src;
        3: b = dst;
        4: b = seq;
        FrameBytes - 2: b = crc[15:8];
        FrameBytes - 1: b = crc[7:0];
        default: begin
          if (pattern == PayCorners) begin
            case (j - 5)
              0: b = 8'h00;
              1: b = 8'hFF;
              2: b = frf_pkg::HeaderByte;
              default: b = 8'((j - 5) * 17);
            endcase
          end else begin
            b = 8'($urandom_range(0, 255));
          end
        end
      endcase
      send_byte(b);
    end
  endtask

  // Stops offering bytes and waits until the block has gone quiet.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes one register; call only while the block is drained.
  task automatic write_reg(input logic [frf_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == frf_pkg::CfgLocalAddr) begin
      local_addr_q = val;
    end else if (idx == frf_pkg::CfgBcastAddr) begin
      bcast_addr_q = val;
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_destination();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return local_addr_q;
    end else if (roll < 6) begin
      return bcast_addr_q;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Reset addresses, ignored bytes while hunting, header byte inside a frame.
  task automatic test_reset_addresses;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_frame(8'hFF, 8'h00, frf_pkg::LocalAddrRst, frf_pkg::HeaderByte, 16'hFFFF,
               PayCorners, FrameBytes);
    send_frame(frf_pkg::HeaderByte, 8'hFF, frf_pkg::BcastAddrRst, 8'h00, 16'h0000,
               PayCorners, FrameBytes);
    // Foreign destination that is also the header value.
    send_frame(8'h12, 8'h34, frf_pkg::HeaderByte, 8'h56, 16'hAA55, PayRandom, FrameBytes);
  endtask

  // Both address registers at 8'hFF, the local address also at 8'h00, plus a write to an unused index.
  task automatic test_address_registers;
    drain();
    write_reg(frf_pkg::CfgLocalAddr, 8'hFF);
    write_reg(frf_pkg::CfgBcastAddr, 8'hFF);
    send_frame(8'h01, 8'h02, 8'hFF, 8'h03, 16'h1234, PayRandom, FrameBytes);
    send_frame(8'h04, 8'h05, 8'h01, 8'h06, 16'h5678, PayRandom, FrameBytes);
    drain();
    write_reg(frf_pkg::CfgLocalAddr, 8'h00);
    write_reg(frf_pkg::CfgBcastAddr, 8'h80);
    write_reg(CfgIdxUnused, 8'h01);
    send_frame(8'h07, 8'h08, 8'h01, 8'h09, 16'h9ABC, PayRandom, FrameBytes);
    send_frame(8'h0A, 8'h0B, 8'h80, 8'h0C, 16'hDEF0, PayRandom, FrameBytes);
    send_frame(8'h0D, 8'h0E, 8'h00, 8'h0F, 16'h0F0F, PayRandom, FrameBytes);
  endtask

  // Mostly whole frames with random content, some noise and truncated frames.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int start;
    int kind;
    drain();
    write_reg(frf_pkg::CfgLocalAddr, 8'($urandom_range(0, 255)));
    write_reg(frf_pkg::CfgBcastAddr, 8'($urandom_range(0, 255)));
    tx_gap_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    start = bytes_taken;
    while (bytes_taken - start < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   pick_destination(), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), PayRandom,
                   (kind == 1) ? $urandom_range(1, FrameBytes - 1) : FrameBytes);
      end
    end
    // Finish any frame left open so the block ends up hunting.
    while (rx_pos != 5'd0) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_back_pressure;
    drain();
    tx_gap_pct = IdleNone;
    rx_stall_pct <= IdleNone;
    hold_left <= HoldCycles;
    repeat (3) begin
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), local_addr_q,
                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), PayRandom,
                 FrameBytes);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    rx_byte_i    = 8'h00;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = frf_pkg::CfgLocalAddr;
    cfg_data_i   = 8'h00;
    tx_gap_pct   = IdleRare;
    rx_stall_pct = IdleOften;
    hold_left    = 0;
    cycle_cnt    = 0;
    mismatches   = 0;
    results_checked = 0;
    bytes_taken  = 0;
    frames_kept  = 0;
    frames_dropped = 0;
    rx_pos       = 5'd0;
    local_addr_q = frf_pkg::LocalAddrRst;
    bcast_addr_q = frf_pkg::BcastAddrRst;
    foreach (frame_body[i]) frame_body[i] = 8'h00;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_addresses();
    test_address_registers();
    test_random_traffic(IdleRare, IdleOften, 50);
    test_random_traffic(IdleOften, IdleRare, 50);
    test_random_traffic(IdleNone, IdleNone, 50);
    test_back_pressure();
    drain();

    $display("Covered %0d frame bytes: %0d frames delivered, %0d frames dropped.",
             bytes_taken, frames_kept, frames_dropped);
    $display("Checked %0d result transactions with %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: fixed_frame_receiver_address_filter.f
rtl/core/frf_pkg.sv
rtl/core/frf_ctrl.sv
rtl/core/frf_datapath.sv
rtl/core/fixed_frame_receiver_address_filter.sv
sim/testbench.sv
